/* hdl/iig_pkg.sv */
package iig_pkg;

   // fixed field widths of the ports
   localparam int PIXEL_W        = 8;
   localparam int TABLE_W        = 28;
   localparam int SIDE_W         = 11;
   localparam int SIDE_RESET     = 1024;

   // per-pixel tags produced by the front end
   typedef struct packed {
      logic first_row;
      logic frame_end;
   } flags_type;

endpackage

/* hdl/integral_image_generator_top.sv */
// summed-area table generator, one pixel per beat in raster order
// an accepted req beat reaches rsp_valid through the queue, the line store read stage and the output register
// throughput: one beat per cycle while rsp_ready holds, set by one line store read and one write per beat
// the 2-entry queue takes up to two more beats while a result waits on rsp_ready
// reset (synchronous, active high) clears positions, row sum, queue and valids;
// side returns to 1024 (clamped to MAX_SIDE); the line store is not cleared
module integral_image_generator_top #(
   parameter int MAX_SIDE   = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [iig_pkg::PIXEL_W-1:0] req_pixel,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [iig_pkg::TABLE_W-1:0] rsp_table_value,
   output logic                        rsp_frame_end,
   input  logic                        csr_wr_en,
   input  logic [iig_pkg::SIDE_W-1:0]  csr_image_side
);
   import iig_pkg::*;

   // column and row positions; the column alone indexes the line store
   localparam int POS_W = $clog2(MAX_SIDE);
   // only the low pixel bits that exist on the port take part
   localparam int PIX_W = (PIXEL_BITS < PIXEL_W) ? PIXEL_BITS : PIXEL_W;
   // a full row sum fits pixel width plus position width, capped at table width
   localparam int SUM_W = (PIX_W + POS_W < TABLE_W) ? PIX_W + POS_W : TABLE_W;
   // wide enough to compare the written side against MAX_SIDE
   localparam int CMP_W = (SIDE_W > POS_W + 1) ? SIDE_W : POS_W + 1;
   localparam int RESET_SIDE = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;
   localparam int Q_W = POS_W + SUM_W + $bits(flags_type);

   // side held as side minus one, already clamped to 1..MAX_SIDE
   logic [POS_W-1:0] side_m1_ff, side_m1_in;
   logic [CMP_W-1:0] side_wide;

   // front to queue
   logic             f_valid, f_ready;
   logic [POS_W-1:0] f_col;
   logic [SUM_W-1:0] f_sum;
   flags_type        f_flags;

   // queue to back
   logic             b_valid, b_ready;
   logic [Q_W-1:0]   q_in_data, q_out_data;
   logic [POS_W-1:0] b_col;
   logic [SUM_W-1:0] b_sum;
   flags_type        b_flags;

   // side register: the user must write it only while idle; the block itself does not enforce it
   assign side_wide = CMP_W'(csr_image_side);

   always_comb begin
      side_m1_in = side_m1_ff;
      if (csr_wr_en) begin
         if (side_wide == '0) begin
            // zero acts as a one-pixel image
            side_m1_in = '0;
         end else if (side_wide > CMP_W'(MAX_SIDE)) begin
            side_m1_in = POS_W'(MAX_SIDE - 1);
         end else begin
            side_m1_in = POS_W'(side_wide - 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_m1_ff <= POS_W'(RESET_SIDE - 1);
      end else begin
         side_m1_ff <= side_m1_in;
      end
   end

   // front: positions, row running sum, first-row and frame-end tags
   iig_front #(
      .POS_W (POS_W),
      .PIX_W (PIX_W),
      .SUM_W (SUM_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_pixel (req_pixel),
      .side_m1   (side_m1_ff),
      .cmd_valid (f_valid),
      .cmd_ready (f_ready),
      .cmd_col   (f_col),
      .cmd_sum   (f_sum),
      .cmd_flags (f_flags)
   );

   assign q_in_data = {f_col, f_sum, f_flags};

   // decoupling queue between front and back
   iig_queue #(
      .DATA_W (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (q_in_data),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_data  (q_out_data)
   );

   assign {b_col, b_sum, b_flags} = q_out_data;

   // back: line store read-modify-write, add, output register
   iig_back #(
      .MAX_SIDE (MAX_SIDE),
      .POS_W    (POS_W),
      .SUM_W    (SUM_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (b_valid),
      .cmd_ready       (b_ready),
      .cmd_col         (b_col),
      .cmd_sum         (b_sum),
      .cmd_flags       (b_flags),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_table_value (rsp_table_value),
      .rsp_frame_end   (rsp_frame_end)
   );

endmodule

/* hdl/iig_queue.sv */
module iig_queue #(
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [DATA_W-1:0] in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DATA_W-1:0] out_data
);
   import iig_pkg::*;

   localparam logic [1:0] FULL = 2'd2;

   logic [DATA_W-1:0] slot_ff [2];
   logic [1:0]        count_ff, count_in;
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic              push, pop;

   assign in_ready  = (count_ff != FULL);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      count_in  = count_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

   // occupancy never leaves 0..2
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

   // a pop without a push drains exactly one entry
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 2'd1))
      else $error("queue pop did not drain an entry");

endmodule

/* hdl/iig_front.sv */
module iig_front #(
   parameter int POS_W  = 10,
   parameter int PIX_W  = 8,
   parameter int SUM_W  = 18
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [iig_pkg::PIXEL_W-1:0] req_pixel,
   input  logic [POS_W-1:0]        side_m1,
   output logic                    cmd_valid,
   input  logic                    cmd_ready,
   output logic [POS_W-1:0]        cmd_col,
   output logic [SUM_W-1:0]        cmd_sum,
   output iig_pkg::flags_type      cmd_flags
);
   import iig_pkg::*;

   logic [POS_W-1:0] col_ff, col_in;
   logic [POS_W-1:0] row_ff, row_in;
   logic [SUM_W-1:0] row_sum_ff, row_sum_in;
   logic             last_col, last_row, accept;
   logic [SUM_W-1:0] sum;

   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;
   assign accept    = req_valid && req_ready;

   // positions past a shrunken side count as the last one
   assign last_col = (col_ff >= side_m1);
   assign last_row = (row_ff >= side_m1);
   assign sum      = row_sum_ff + SUM_W'(req_pixel[PIX_W-1:0]);

   assign cmd_col             = last_col ? side_m1 : col_ff;
   assign cmd_sum             = sum;
   assign cmd_flags.first_row = (row_ff == '0);
   assign cmd_flags.frame_end = last_col && last_row;

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      row_sum_in = row_sum_ff;
      if (accept) begin
         if (last_col) begin
            col_in     = '0;
            row_sum_in = '0;
            row_in     = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in     = col_ff + 1'b1;
            row_sum_in = sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         row_sum_ff <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         row_sum_ff <= row_sum_in;
      end
   end

   // the last pixel of a frame sends both positions home
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd_flags.frame_end) |=> (col_ff == '0 && row_ff == '0 && row_sum_ff == '0))
      else $error("positions not cleared after frame end");

endmodule

/* hdl/iig_back.sv */
module iig_back #(
   parameter int MAX_SIDE = 1024,
   parameter int POS_W    = 10,
   parameter int SUM_W    = 18
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   output logic                        cmd_ready,
   input  logic [POS_W-1:0]            cmd_col,
   input  logic [SUM_W-1:0]            cmd_sum,
   input  iig_pkg::flags_type          cmd_flags,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [iig_pkg::TABLE_W-1:0] rsp_table_value,
   output logic                        rsp_frame_end
);
   import iig_pkg::*;

   logic [TABLE_W-1:0] line_mem [MAX_SIDE];
   logic [TABLE_W-1:0] rd_data_ff;

   logic               s1_valid_ff, s1_valid_in;
   logic [POS_W-1:0]   s1_col_ff;
   logic [SUM_W-1:0]   s1_sum_ff;
   flags_type          s1_flags_ff;

   logic               byp_valid_ff, byp_valid_in;
   logic [POS_W-1:0]   byp_col_ff;
   logic [TABLE_W-1:0] byp_value_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [TABLE_W-1:0] rsp_value_ff;
   logic               rsp_end_ff;

   logic               pop, s1_fire;
   logic [TABLE_W-1:0] above, value;

   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign cmd_ready = !s1_valid_ff || s1_fire;
   assign pop       = cmd_valid && cmd_ready;

   // bypass holds the newest line store write, covering a read issued
   // on the same edge as that write
   always_comb begin
      if (s1_flags_ff.first_row) begin
         above = '0;
      end else if (byp_valid_ff && byp_col_ff == s1_col_ff) begin
         above = byp_value_ff;
      end else begin
         above = rd_data_ff;
      end
   end

   assign value = above + TABLE_W'(s1_sum_ff);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (pop) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      byp_valid_in = byp_valid_ff || s1_fire;
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         byp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         byp_valid_ff <= byp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // line store: one read and one write port
   always_ff @(posedge clock) begin
      if (pop) begin
         rd_data_ff <= line_mem[cmd_col];
      end
      if (s1_fire) begin
         line_mem[s1_col_ff] <= value;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_col_ff   <= cmd_col;
         s1_sum_ff   <= cmd_sum;
         s1_flags_ff <= cmd_flags;
      end
      if (s1_fire) begin
         byp_col_ff   <= s1_col_ff;
         byp_value_ff <= value;
         rsp_value_ff <= value;
         rsp_end_ff   <= s1_flags_ff.frame_end;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_table_value = rsp_value_ff;
   assign rsp_frame_end   = rsp_end_ff;

   // a finished pixel always lands in the output register
   a_fire_shows: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff)
      else $error("fired pixel missing from output");

   // a stalled pixel is never replaced
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_fire) |=> (s1_valid_ff && $stable(s1_col_ff) && $stable(s1_sum_ff)))
      else $error("stalled pixel overwritten");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
   import iig_pkg::*;

   localparam int MAX_SIDE = 1024;
   localparam int RANDOM_ITEMS = 800;

   // expected summed-area values, kept in step with the accepted pixel beats
   class sat_scoreboard;
      typedef struct {
         logic [TABLE_W-1:0] table_value;
         logic               frame_end;
      } sat_beat;

      logic [SIDE_W-1:0]  side_reg;
      logic [17:0]        row_sum;
      logic [TABLE_W-1:0] line_store [MAX_SIDE];
      int unsigned        col_pos;
      int unsigned        row_pos;
      sat_beat            expected_q [$];
      int unsigned        errors;

      function new();
         side_reg = SIDE_W'(SIDE_RESET);
         row_sum  = '0;
         col_pos  = 0;
         row_pos  = 0;
         errors   = 0;
         foreach (line_store[i]) line_store[i] = '0;
      endfunction

      function int unsigned eff_side(logic [SIDE_W-1:0] v);
         if (v == 0) return 1;
         if (v > MAX_SIDE) return MAX_SIDE;
         return v;
      endfunction

      function void note_side(logic [SIDE_W-1:0] v);
         side_reg = v;
      endfunction

      // growing past the old side below the first row would read unwritten store entries
      function bit side_safe(logic [SIDE_W-1:0] v);
         return (row_pos == 0) || (eff_side(v) <= eff_side(side_reg));
      endfunction

      function int unsigned left_in_frame();
         int unsigned side, c, r;
         side = eff_side(side_reg);
         c = (col_pos >= side) ? side - 1 : col_pos;
         r = (row_pos >= side) ? side - 1 : row_pos;
         return (side - 1 - r) * side + (side - c);
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void note_pixel(logic [PIXEL_W-1:0] p);
         int unsigned        side, col;
         logic               last_col, last_row;
         logic [TABLE_W-1:0] above, value;
         sat_beat            b;
         side     = eff_side(side_reg);
         col      = (col_pos >= side) ? side - 1 : col_pos;
         last_col = (col + 1 >= side);
         last_row = (row_pos + 1 >= side);
         row_sum  = row_sum + 18'(p);
         above    = (row_pos == 0) ? '0 : line_store[col];
         value    = above + TABLE_W'(row_sum);
         line_store[col] = value;
         b.table_value = value;
         b.frame_end   = last_col && last_row;
         expected_q.push_back(b);
         if (last_col) begin
            col_pos = 0;
            row_sum = '0;
            row_pos = last_row ? 0 : row_pos + 1;
         end else begin
            col_pos = col + 1;
         end
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(logic [TABLE_W-1:0] tv, logic fe);
         sat_beat b;
         if (expected_q.size() == 0) begin
            report($sformatf("result beat with nothing expected, table_value=%0d", tv));
            return;
         end
         b = expected_q.pop_front();
         if (tv !== b.table_value)
            report($sformatf("table_value %0d, expected %0d", tv, b.table_value));
         if (fe !== b.frame_end)
            report($sformatf("frame_end %0b, expected %0b", fe, b.frame_end));
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [PIXEL_W-1:0] req_pixel = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [TABLE_W-1:0] rsp_table_value;
   logic               rsp_frame_end;
   logic               csr_wr_en = 1'b0;
   logic [SIDE_W-1:0]  csr_image_side = SIDE_W'(SIDE_RESET);

   // set during a stretch of the random part: neither side idles
   bit steady = 1'b0;

   sat_scoreboard sb = new();

   integral_image_generator_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel       (req_pixel),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_table_value (rsp_table_value),
      .rsp_frame_end   (rsp_frame_end),
      .csr_wr_en       (csr_wr_en),
      .csr_image_side  (csr_image_side)
   );

   always #5 clock = ~clock;

   // receiver back-pressure, changed on the falling edge only
   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 29);
   end

   // every accepted result beat goes against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_table_value, rsp_frame_end);
   end

   // one pixel beat: random idle cycles first, then hold valid until accepted
   // entered and left on a falling edge
   task automatic send_pixel(input logic [PIXEL_W-1:0] p);
      while (!steady && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_pixel(p);
      @(negedge clock);
   endtask

   // stop sending and wait for every expected beat, with a cycle limit
   task automatic drain_results();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      while (sb.pending() != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      if (sb.pending() != 0)
         sb.report($sformatf("%0d expected beats never arrived", sb.pending()));
   endtask

   // side register write, only with the block drained
   task automatic write_side(input logic [SIDE_W-1:0] v);
      csr_wr_en      <= 1'b1;
      csr_image_side <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.note_side(v);
   endtask

   // run limit, far beyond the slowest passing run
   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      int unsigned       sent, n, r;
      logic [SIDE_W-1:0] v;

      // synchronous reset held, then released on a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // first row at the reset side of 1024, full-scale and zero pixels
      send_pixel(8'd255); send_pixel(8'd255); send_pixel(8'd0); send_pixel(8'd255);
      drain_results();

      // shrink mid row: column past the new side counts as the last one
      write_side(SIDE_W'(2));
      send_pixel(8'd255); send_pixel(8'd0); send_pixel(8'd255);
      drain_results();

      // zero side acts as one, so every beat closes a frame
      write_side(SIDE_W'(0));
      send_pixel(8'd255); send_pixel(8'd0); send_pixel(8'd128);
      drain_results();

      // side above range clamps to 1024, grown on the first row
      write_side(SIDE_W'(2047));
      send_pixel(8'd1); send_pixel(8'd2); send_pixel(8'd4); send_pixel(8'd8);
      send_pixel(8'd16);
      drain_results();

      // shrink to 3 mid row, then finish the 3x3 frame
      write_side(SIDE_W'(3));
      send_pixel(8'd32); send_pixel(8'd64); send_pixel(8'd128); send_pixel(8'd255);
      send_pixel(8'd255); send_pixel(8'd255); send_pixel(8'd170);
      drain_results();

      // smallest legal side
      write_side(SIDE_W'(1));
      send_pixel(8'd85); send_pixel(8'd255);
      drain_results();

      // random phases: side write between drained phases, then a run of pixels
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         steady = (sent >= 300 && sent < 450);
         if ($urandom_range(99) < 70) begin
            r = $urandom_range(99);
            if (r < 5)       v = SIDE_W'(0);
            else if (r < 8)  v = SIDE_W'($urandom_range(1025, 2047));
            else if (r < 11) v = SIDE_W'(MAX_SIDE);
            else if (r < 22) v = SIDE_W'($urandom_range(17, 64));
            else             v = SIDE_W'($urandom_range(1, 16));
            // below the first row only shrink
            if (!sb.side_safe(v))
               v = SIDE_W'($urandom_range(1, sb.eff_side(sb.side_reg)));
            write_side(v);
         end
         // mostly finish the frame in progress, else a short broken run
         n = sb.left_in_frame();
         if ($urandom_range(99) >= 60 || n > 150)
            n = $urandom_range(1, 40);
         repeat (n) begin
            r = $urandom_range(99);
            if (r < 10)      send_pixel(8'd0);
            else if (r < 20) send_pixel(8'd255);
            else             send_pixel(PIXEL_W'($urandom_range(0, 255)));
            sent++;
         end
         drain_results();
      end
      steady = 1'b0;

      // settle past the pipeline latency, catching stray beats
      repeat (10) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
